// ===== rtl/rlfw_pkg.sv =====
// Shared constants, types and controller states for the resource lock manager.
// No dependencies.
package rlfw_pkg;

    localparam int NUM_RESOURCES = 5;
    localparam int QUEUE_DEPTH   = 16;
    localparam int ID_BITS       = 4;

    localparam int TYPE_W   = 1;
    localparam int RES_IN_W = 3;
    localparam int ID_IN_W  = 4;

    localparam int RES_IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [TYPE_W-1:0] REQ_ACQUIRE = 1'b0;
    localparam logic [TYPE_W-1:0] REQ_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== rtl/rlfw_ctrl.sv =====
// Controller state machine: sequences capture, execution and result beat.
// Depends on rlfw_pkg.
module rlfw_ctrl
    import rlfw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rlfw_dp.sv =====
// Datapath: free flags, per-resource queue pointers and counts, wait-id memory
// and result registers. Depends on rlfw_pkg.
module rlfw_dp
    import rlfw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [TYPE_W-1:0]   i_req_type,
    input  logic [RES_IN_W-1:0] i_resource,
    input  logic [ID_IN_W-1:0]  i_requester_id,
    output logic                o_granted,
    output logic                o_queued,
    output logic                o_overflow,
    output logic                o_woken_valid,
    output logic [ID_IN_W-1:0]  o_woken_id
);

    logic [TYPE_W-1:0]        r_req_type;
    logic [RES_IN_W-1:0]      r_res;
    logic [ID_BITS-1:0]       r_id;

    logic [NUM_RESOURCES-1:0] r_free;
    logic [PTR_W-1:0]         r_head  [NUM_RESOURCES];
    logic [PTR_W-1:0]         r_tail  [NUM_RESOURCES];
    logic [CNT_W-1:0]         r_count [NUM_RESOURCES];

    logic [ID_BITS-1:0]       r_mem [MEM_DEPTH];
    logic [ID_BITS-1:0]       r_rd_data;

    logic                     r_granted;
    logic                     r_queued;
    logic                     r_overflow;
    logic                     r_wv;

    logic                     in_range;
    logic [RES_IDX_W-1:0]     idx;
    logic                     is_free;
    logic                     q_full;
    logic                     q_empty;
    logic                     do_grant;
    logic                     do_queue;
    logic                     do_ovf;
    logic                     do_release;
    logic                     do_pop;
    logic [PTR_W-1:0]         head_cur;
    logic [PTR_W-1:0]         tail_cur;
    logic [PTR_W-1:0]         n_head;
    logic [PTR_W-1:0]         n_tail;
    logic [ADDR_W-1:0]        base_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;

    always_comb begin
        in_range  = (32'(r_res) < 32'(NUM_RESOURCES));
        idx       = RES_IDX_W'(r_res);
        is_free   = r_free[idx];
        head_cur  = r_head[idx];
        tail_cur  = r_tail[idx];
        q_full    = (r_count[idx] == CNT_W'(QUEUE_DEPTH));
        q_empty   = (r_count[idx] == '0);
        n_head    = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
        n_tail    = (tail_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + 1'b1;
        base_addr = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH);
        wr_addr   = base_addr + ADDR_W'(tail_cur);
        rd_addr   = base_addr + ADDR_W'(head_cur);

        do_grant   = i_cmd.exec && in_range && (r_req_type == REQ_ACQUIRE) && is_free;
        do_ovf     = i_cmd.exec && in_range && (r_req_type == REQ_ACQUIRE) && !is_free
                     && q_full;
        do_queue   = i_cmd.exec && in_range && (r_req_type == REQ_ACQUIRE) && !is_free
                     && !q_full;
        do_release = i_cmd.exec && in_range && (r_req_type == REQ_RELEASE);
        do_pop     = do_release && !q_empty;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_res      <= i_resource;
            r_id       <= ID_BITS'(i_requester_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
            for (int i = 0; i < NUM_RESOURCES; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (do_grant) begin
                r_free[idx] <= 1'b0;
            end
            if (do_release) begin
                r_free[idx] <= 1'b1;
            end
            if (do_queue) begin
                r_tail[idx]  <= n_tail;
                r_count[idx] <= r_count[idx] + 1'b1;
            end
            if (do_pop) begin
                r_head[idx]  <= n_head;
                r_count[idx] <= r_count[idx] - 1'b1;
            end
        end
    end

    // wait-id memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_queue) begin
            r_mem[wr_addr] <= r_id;
        end
        if (do_pop) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_granted  <= 1'b0;
            r_queued   <= 1'b0;
            r_overflow <= 1'b0;
            r_wv       <= 1'b0;
        end else if (i_cmd.exec) begin
            r_granted  <= do_grant;
            r_queued   <= do_queue;
            r_overflow <= do_ovf;
            r_wv       <= do_pop;
        end
    end

    assign o_granted     = r_granted;
    assign o_queued      = r_queued;
    assign o_overflow    = r_overflow;
    assign o_woken_valid = r_wv;
    assign o_woken_id    = r_wv ? ID_IN_W'(r_rd_data) : '0;

endmodule

// ===== rtl/resource_lock_fifo_waiters.sv =====
// Top level of the resource lock manager: controller plus datapath.
// Depends on rlfw_pkg, rlfw_ctrl and rlfw_dp.
//
// Lock manager for NUM_RESOURCES single-unit resources, each with a wait queue
// of QUEUE_DEPTH requester ids. Every beat passes through capture into the
// input registers, an execute step in which the resource's flag, pointers and
// count are updated and the wait memory is written or read, and a result step,
// held while i_stall is high, that shows the registered result and the woken
// id from the registered read of the wait memory.
// Out-of-range resource indexes change nothing and give an all-zero result.
// A release does not pass ownership on: the woken requester must ask again.
module resource_lock_fifo_waiters
    import rlfw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [TYPE_W-1:0]   i_req_type,
    input  logic [RES_IN_W-1:0] i_resource,
    input  logic [ID_IN_W-1:0]  i_requester_id,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_granted,
    output logic                o_queued,
    output logic                o_overflow,
    output logic                o_woken_valid,
    output logic [ID_IN_W-1:0]  o_woken_id
);

    t_dp_cmd cmd;

    rlfw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    rlfw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_resource     (i_resource),
        .i_requester_id (i_requester_id),
        .o_granted      (o_granted),
        .o_queued       (o_queued),
        .o_overflow     (o_overflow),
        .o_woken_valid  (o_woken_valid),
        .o_woken_id     (o_woken_id)
    );

endmodule

// ===== verif/resource_lock_fifo_waiters_test.sv =====
// Self-checking testbench for resource_lock_fifo_waiters: a directed table, then
// random acquire/release traffic, each result checked against the table or a lock model.
// Depends on rlfw_pkg and the resource_lock_fifo_waiters RTL.
`timescale 1ns / 100ps

module resource_lock_fifo_waiters_test
    import rlfw_pkg::*;
();

    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PLAN_ROWS    = 19;

    typedef struct packed {
        logic               granted;
        logic               queued;
        logic               overflow;
        logic               woken_valid;
        logic [ID_IN_W-1:0] woken_id;
    } t_lock_result;

    typedef struct packed {
        logic [TYPE_W-1:0]   kind;
        logic [RES_IN_W-1:0] res;
        logic [ID_IN_W-1:0]  id;
        logic [4:0]          reps;
        logic                typed;
        t_lock_result        want;
    } t_plan_row;

    localparam t_lock_result R_NONE     = '0;
    localparam t_lock_result R_GRANT    = '{1'b1, 1'b0, 1'b0, 1'b0, '0};
    localparam t_lock_result R_QUEUED   = '{1'b0, 1'b1, 1'b0, 1'b0, '0};
    localparam t_lock_result R_OVERFLOW = '{1'b0, 1'b0, 1'b1, 1'b0, '0};
    localparam t_lock_result R_WOKE_15  = '{1'b0, 1'b0, 1'b0, 1'b1, 4'd15};

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    logic [TYPE_W-1:0]   i_req_type     = REQ_ACQUIRE;
    logic [RES_IN_W-1:0] i_resource     = '0;
    logic [ID_IN_W-1:0]  i_requester_id = '0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic                o_granted;
    logic                o_queued;
    logic                o_overflow;
    logic                o_woken_valid;
    logic [ID_IN_W-1:0]  o_woken_id;

    // lock model state
    logic               res_free   [NUM_RESOURCES];
    logic [ID_IN_W-1:0] waiters    [NUM_RESOURCES][QUEUE_DEPTH];
    int                 head_ptr   [NUM_RESOURCES];
    int                 tail_ptr   [NUM_RESOURCES];
    int                 waiting    [NUM_RESOURCES];

    t_lock_result pending_results[$];
    t_plan_row    plan [0:PLAN_ROWS-1];
    int           errors     = 0;
    int           cycles     = 0;
    int           stall_left = 0;
    bit           calm       = 1'b0;

    resource_lock_fifo_waiters u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_resource     (i_resource),
        .i_requester_id (i_requester_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_granted      (o_granted),
        .o_queued       (o_queued),
        .o_overflow     (o_overflow),
        .o_woken_valid  (o_woken_valid),
        .o_woken_id     (o_woken_id)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 70)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Applies one beat to the lock model and returns the result it yields.
    function automatic t_lock_result predict_lock(input logic [TYPE_W-1:0] kind,
                                                  input logic [RES_IN_W-1:0] res,
                                                  input logic [ID_IN_W-1:0] id);
        t_lock_result r;
        int n;
        r = R_NONE;
        n = res;
        if (n < NUM_RESOURCES) begin
            if (kind == REQ_ACQUIRE) begin
                if (res_free[n]) begin
                    res_free[n] = 1'b0;
                    r.granted = 1'b1;
                end else if (waiting[n] >= QUEUE_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    waiters[n][tail_ptr[n]] = id;
                    tail_ptr[n] = (tail_ptr[n] + 1) % QUEUE_DEPTH;
                    waiting[n]++;
                    r.queued = 1'b1;
                end
            end else begin
                res_free[n] = 1'b1;
                if (waiting[n] != 0) begin
                    r.woken_valid = 1'b1;
                    r.woken_id = waiters[n][head_ptr[n]];
                    head_ptr[n] = (head_ptr[n] + 1) % QUEUE_DEPTH;
                    waiting[n]--;
                end
            end
        end
        return r;
    endfunction

    // Drives one beat and holds it until accepted; the expectation is queued at acceptance.
    task automatic send_beat(input logic [TYPE_W-1:0] kind, input logic [RES_IN_W-1:0] res,
                             input logic [ID_IN_W-1:0] id, input bit typed,
                             input t_lock_result want);
        t_lock_result got;
        int gap;
        i_valid        <= 1'b1;
        i_req_type     <= kind;
        i_resource     <= res;
        i_requester_id <= id;
        do
            @(posedge i_clk);
        while (o_stall);
        got = predict_lock(kind, res, id);
        pending_results.push_back(typed ? want : got);
        gap = gap_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (pending_results.size() != 0) begin
            i_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lock_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected, expected none got %0h",
                         $realtime, {o_granted, o_queued, o_overflow, o_woken_valid,
                         o_woken_id});
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("granted", want.granted, o_granted);
                check_field("queued", want.queued, o_queued);
                check_field("overflow", want.overflow, o_overflow);
                check_field("woken_valid", want.woken_valid, o_woken_valid);
                check_field("woken_id", want.woken_id, o_woken_id);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left <= gap_len();
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        int done;
        int acq_pct;
        int hot;
        logic [TYPE_W-1:0]   kind;
        logic [RES_IN_W-1:0] res;

        for (int n = 0; n < NUM_RESOURCES; n++) begin
            res_free[n] = 1'b1;
            head_ptr[n] = 0;
            tail_ptr[n] = 0;
            waiting[n]  = 0;
            for (int k = 0; k < QUEUE_DEPTH; k++)
                waiters[n][k] = '0;
        end

        plan = '{
            '{REQ_ACQUIRE, 3'd0, 4'd0,  5'd1,  1'b1, R_GRANT},
            '{REQ_ACQUIRE, 3'd0, 4'd15, 5'd1,  1'b1, R_QUEUED},
            '{REQ_RELEASE, 3'd0, 4'd0,  5'd1,  1'b1, R_WOKE_15},
            '{REQ_RELEASE, 3'd0, 4'd0,  5'd1,  1'b1, R_NONE},
            '{REQ_RELEASE, 3'd1, 4'd15, 5'd1,  1'b1, R_NONE},
            '{REQ_ACQUIRE, 3'd5, 4'd15, 5'd1,  1'b1, R_NONE},
            '{REQ_RELEASE, 3'd7, 4'd15, 5'd1,  1'b1, R_NONE},
            '{REQ_ACQUIRE, 3'd6, 4'd9,  5'd1,  1'b1, R_NONE},
            '{REQ_ACQUIRE, 3'd4, 4'd3,  5'd1,  1'b1, R_GRANT},
            '{REQ_ACQUIRE, 3'd4, 4'd0,  5'd16, 1'b0, R_NONE},
            '{REQ_ACQUIRE, 3'd4, 4'd9,  5'd1,  1'b1, R_OVERFLOW},
            '{REQ_RELEASE, 3'd4, 4'd0,  5'd1,  1'b0, R_NONE},
            '{REQ_RELEASE, 3'd4, 4'd0,  5'd1,  1'b0, R_NONE},
            '{REQ_ACQUIRE, 3'd4, 4'd12, 5'd1,  1'b0, R_NONE},
            '{REQ_ACQUIRE, 3'd1, 4'd8,  5'd1,  1'b1, R_GRANT},
            '{REQ_ACQUIRE, 3'd2, 4'd6,  5'd1,  1'b1, R_GRANT},
            '{REQ_ACQUIRE, 3'd3, 4'd2,  5'd1,  1'b1, R_GRANT},
            '{REQ_ACQUIRE, 3'd3, 4'd10, 5'd1,  1'b0, R_NONE},
            '{REQ_RELEASE, 3'd3, 4'd5,  5'd1,  1'b0, R_NONE}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; the fill row steps the id on each repeat
        foreach (plan[row])
            for (int k = 0; k < plan[row].reps; k++)
                send_beat(plan[row].kind, plan[row].res, plan[row].id + k[ID_IN_W-1:0],
                          plan[row].typed, plan[row].want);

        drain();

        done    = 0;
        acq_pct = 50;
        hot     = 0;
        while (done < RANDOM_ITEMS) begin
            if (done % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: acq_pct = 95;
                    1: acq_pct = 70;
                    2: acq_pct = 50;
                    default: acq_pct = 25;
                endcase
                hot  = $urandom_range(0, NUM_RESOURCES - 1);
                calm = ($urandom_range(0, 3) == 0);
            end
            if (done == RANDOM_ITEMS / 2)
                drain();
            res  = ($urandom_range(0, 9) < 6) ? RES_IN_W'(hot) : RES_IN_W'($urandom_range(0, 7));
            kind = ($urandom_range(0, 99) < acq_pct) ? REQ_ACQUIRE : REQ_RELEASE;
            send_beat(kind, res, ID_IN_W'($urandom_range(0, 15)), 1'b0, R_NONE);
            done++;
        end

        drain();
        repeat (10) @(posedge i_clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
